### sv/sbda_pkg.sv
// Shared constants and controller/datapath interface types for the decimal ASCII converter.
package sbda_pkg;

   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [3:0] BCD_LIMIT  = 4'd5;
   localparam logic [3:0] BCD_ADJUST = 4'd3;

   typedef struct packed {
      logic load;        // capture the input value and clear the BCD register
      logic conv_step;   // one shift-and-add-3 step
      logic digit_shift; // drop the top BCD digit
      logic sign_out;    // load a minus sign into the output register
      logic digit_out;   // load the top digit into the output register
      logic digit_last;  // the digit being loaded ends the number's text
   } sbda_cmd_type;

   typedef struct packed {
      logic negative;
      logic top_zero;
      logic out_free;
   } sbda_status_type;

endpackage

### sv/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
//
//   Channel   Ports                                       Direction
//   request   req_valid, req_stall, req_value             in (stall out)
//   response  rsp_valid, rsp_stall, rsp_character, rsp_last  out (stall in)
//
// One transaction runs a load, VALUE_BITS double-dabble steps, one shift per dropped leading
// zero, a step to leave the zero skip and one step per emitted character, with a minus sign
// emitted first for a negative value.
// The shift-and-add-3 loop over the BCD register sets the conversion time.
// Reset is synchronous and active high; it clears the controller and the output valid.
// A response stall holds the output register and pauses emission; a new request is
// taken only once the previous number's last character is in the output register.
module signed_binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);
   import sbda_pkg::*;

   // Decimal digits of 2^(VALUE_BITS-1), the largest magnitude.
   localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

   sbda_cmd_type    cmd;
   sbda_status_type status;

   sbda_ctrl #(
      .VALUE_BITS(VALUE_BITS),
      .DIGITS    (DIGITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   sbda_datapath #(
      .VALUE_BITS(VALUE_BITS),
      .DIGITS    (DIGITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .value        (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

endmodule

### sv/sbda_datapath.sv
// Datapath: magnitude register, double-dabble BCD register and the output register.
module sbda_datapath #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [VALUE_BITS-1:0]    value,
   input  sbda_pkg::sbda_cmd_type   cmd,
   output sbda_pkg::sbda_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_character,
   output logic                     rsp_last
);
   import sbda_pkg::*;

   localparam int BCD_BITS = 4 * DIGITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic                  neg_ff, neg_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic [3:0]            top_digit;
   logic                  out_free;

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];
   assign out_free  = !valid_ff || !rsp_stall;

   // Add-3 correction on every digit that is five or more, ahead of the shift.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= BCD_LIMIT) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + BCD_ADJUST;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         neg_in = value[VALUE_BITS-1];
         // The negated most negative value reads correctly as an unsigned magnitude.
         mag_in = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
         bcd_in = '0;
      end else if (cmd.conv_step) begin
         bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
      end else if (cmd.digit_shift) begin
         bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.sign_out) begin
         valid_in = 1'b1;
         char_in  = CHAR_MINUS;
         last_in  = 1'b0;
      end else if (cmd.digit_out) begin
         valid_in = 1'b1;
         char_in  = CHAR_ZERO + {4'd0, top_digit};
         last_in  = cmd.digit_last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.negative = neg_ff;
   assign status.top_zero = (top_digit == 4'd0);
   assign status.out_free = out_free;

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

### sv/sbda_ctrl.sv
// Controller state machine: sequences load, conversion steps, sign and digit emission.
module sbda_ctrl #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sbda_pkg::sbda_status_type status,
   output sbda_pkg::sbda_cmd_type    cmd
);
   import sbda_pkg::*;

   localparam int BIT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_W = $clog2(DIGITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [BIT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic             one_digit_left;

   assign req_stall      = (state_ff != ST_IDLE);
   assign one_digit_left = (dig_cnt_ff == DIG_W'(1));

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_W'(VALUE_BITS);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            bit_cnt_in    = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == BIT_W'(1)) begin
               dig_cnt_in = DIG_W'(DIGITS);
               state_in   = status.negative ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.sign_out = 1'b1;
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped, but the units digit always stays.
            if (status.top_zero && !one_digit_left) begin
               cmd.digit_shift = 1'b1;
               dig_cnt_in      = dig_cnt_ff - DIG_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.digit_out   = 1'b1;
               cmd.digit_last  = one_digit_left;
               cmd.digit_shift = 1'b1;
               dig_cnt_in      = dig_cnt_ff - DIG_W'(1);
               if (one_digit_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

endmodule
